>>> rtl/hcl_pkg.sv
// Shared types and constants of the HTTP content-length scanner.
`default_nettype none

package hcl_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned VALUE_W = 30;

	localparam logic [VALUE_W-1:0] VALUE_CAP        = '1;
	localparam logic [VALUE_W-1:0] MAX_LENGTH_RESET = 30'd1000000000;

	// One result beat.
	typedef struct packed {
		logic               length_found;
		logic [VALUE_W-1:0] content_length;
		logic               ended_by_blank_line;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/hcl_if.sv
// Valid/ready channel interfaces for header bytes and scan results.
`default_nettype none

interface hcl_in_if;
	logic                          valid;
	logic                          ready;
	logic [hcl_pkg::BYTE_W-1:0]    byte_value;
	logic                          end_of_message;

	modport source (output valid, output byte_value, output end_of_message, input ready);
	modport sink   (input valid, input byte_value, input end_of_message, output ready);
endinterface

interface hcl_out_if;
	logic                          valid;
	logic                          ready;
	logic                          length_found;
	logic [hcl_pkg::VALUE_W-1:0]   content_length;
	logic                          ended_by_blank_line;

	modport source (output valid, output length_found, output content_length,
		output ended_by_blank_line, input ready);
	modport sink   (input valid, input length_found, input content_length,
		input ended_by_blank_line, output ready);
endinterface

`default_nettype wire

>>> rtl/hcl_scan_core.sv
// Per-byte line parser: holds message state and updates it once per byte.
`default_nettype none

module hcl_scan_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fire,
	input  wire logic [hcl_pkg::BYTE_W-1:0]   byte_value,
	input  wire logic                         end_of_message,
	input  wire logic [hcl_pkg::VALUE_W-1:0]  max_length,
	output logic                              res_valid,
	output hcl_pkg::result_t                  res
);

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [3:0] NAME_LEN = 4'd14;

	typedef enum logic [2:0] {
		PH_NAME_LEAD,
		PH_NAME_BODY,
		PH_VAL_LEAD,
		PH_VAL_DIGITS,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		phase_t                      phase;
		logic                        nonempty;
		logic [3:0]                  idx;
		logic                        match;
		logic                        trail;
		logic                        digit_seen;
		logic [hcl_pkg::VALUE_W-1:0] acc;
		logic                        too_large;
	} line_t;

	typedef struct packed {
		logic                        found;
		logic [hcl_pkg::VALUE_W-1:0] len;
	} stored_t;

	localparam line_t LINE_CLEAR = '{
		phase: PH_NAME_LEAD, nonempty: 1'b0, idx: 4'd0, match: 1'b1, trail: 1'b0,
		digit_seen: 1'b0, acc: '0, too_large: 1'b0
	};
	localparam stored_t STORED_CLEAR = '{found: 1'b0, len: '0};

	// "content-length", lower case
	function automatic logic [7:0] target_char(logic [3:0] i);
		logic [7:0] c;
		unique case (i)
			4'd0:    c = 8'h63;
			4'd1:    c = 8'h6f;
			4'd2:    c = 8'h6e;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6e;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2d;
			4'd8:    c = 8'h6c;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6e;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_blank(logic [7:0] b);
		return (b == CH_SP) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
	endfunction

	function automatic line_t compare_name(line_t l, logic [7:0] b);
		line_t      n;
		logic [7:0] low;
		n   = l;
		low = (b >= 8'h41 && b <= 8'h5a) ? (b + 8'd32) : b;
		if (l.trail)
			n.match = 1'b0;
		if (l.idx < NAME_LEN && low == target_char(l.idx))
			n.idx = l.idx + 4'd1;
		else
			n.match = 1'b0;
		return n;
	endfunction

	function automatic line_t add_digit(line_t l, logic [3:0] d);
		line_t                         n;
		logic [hcl_pkg::VALUE_W+3:0]   v;
		n = l;
		// acc * 10 + d as shift-and-add
		v = ({4'b0, l.acc} << 3) + ({4'b0, l.acc} << 1) + {{hcl_pkg::VALUE_W{1'b0}}, d};
		if (!l.too_large) begin
			if (v > {4'b0, hcl_pkg::VALUE_CAP})
				n.too_large = 1'b1;
			else
				n.acc = v[hcl_pkg::VALUE_W-1:0];
		end
		return n;
	endfunction

	function automatic line_t content_byte(line_t l, logic [7:0] b);
		line_t n;
		logic  digit;
		n          = l;
		n.nonempty = 1'b1;
		digit      = (b >= 8'h30) && (b <= 8'h39);
		unique case (l.phase)
			PH_NAME_LEAD: begin
				if (b == CH_COLON)
					n.phase = PH_SKIP;
				else if (!is_blank(b)) begin
					n       = compare_name(n, b);
					n.phase = PH_NAME_BODY;
				end
			end
			PH_NAME_BODY: begin
				if (b == CH_COLON)
					n.phase = (l.match && l.idx == NAME_LEN) ? PH_VAL_LEAD : PH_SKIP;
				else if (is_blank(b))
					n.trail = 1'b1;
				else
					n = compare_name(n, b);
			end
			PH_VAL_LEAD: begin
				if (digit) begin
					n            = add_digit(n, b[3:0]);
					n.digit_seen = 1'b1;
					n.phase      = PH_VAL_DIGITS;
				end else if (!is_blank(b))
					n.phase = PH_SKIP;
			end
			PH_VAL_DIGITS: begin
				if (digit)
					n = add_digit(n, b[3:0]);
				else
					n.phase = PH_SKIP;
			end
			default: ;
		endcase
		return n;
	endfunction

	function automatic stored_t end_line(line_t l, stored_t s, logic [hcl_pkg::VALUE_W-1:0] lim);
		stored_t n;
		n = s;
		if (l.digit_seen && !l.too_large && l.acc <= lim) begin
			n.found = 1'b1;
			n.len   = l.acc;
		end
		return n;
	endfunction

	line_t   line_q, line_d;
	stored_t stored_q, stored_d;
	logic    prev_cr_q, prev_cr_d;
	logic    done_q, done_d;
	logic    blank;
	logic    used;

	always_comb begin
		line_d    = line_q;
		stored_d  = stored_q;
		prev_cr_d = prev_cr_q;
		done_d    = done_q;
		res_valid = 1'b0;
		blank     = 1'b0;
		used      = 1'b0;
		res       = '0;

		if (!done_q) begin
			if (prev_cr_q) begin
				prev_cr_d = 1'b0;
				if (byte_value == CH_LF) begin
					used = 1'b1;
					if (!line_q.nonempty) begin
						res_valid = 1'b1;
						blank     = 1'b1;
						done_d    = 1'b1;
					end else begin
						stored_d = end_line(line_q, stored_q, max_length);
						line_d   = LINE_CLEAR;
					end
				end else
					line_d = content_byte(line_q, CH_CR);
			end
			if (!used) begin
				if (byte_value == CH_CR)
					prev_cr_d = 1'b1;
				else
					line_d = content_byte(line_d, byte_value);
			end
		end

		if (end_of_message && !done_d) begin
			// a held CR at message end is a plain line byte
			if (prev_cr_d)
				line_d = content_byte(line_d, CH_CR);
			stored_d  = end_line(line_d, stored_d, max_length);
			res_valid = 1'b1;
		end

		res.length_found        = stored_d.found;
		res.content_length      = stored_d.found ? stored_d.len : '0;
		res.ended_by_blank_line = blank;

		if (end_of_message) begin
			line_d    = LINE_CLEAR;
			stored_d  = STORED_CLEAR;
			prev_cr_d = 1'b0;
			done_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q    <= LINE_CLEAR;
			stored_q  <= STORED_CLEAR;
			prev_cr_q <= 1'b0;
			done_q    <= 1'b0;
		end else if (fire) begin
			line_q    <= line_d;
			stored_q  <= stored_d;
			prev_cr_q <= prev_cr_d;
			done_q    <= done_d;
		end
	end

	// after the blank line nothing more may come out of this message
	a_no_res_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !res_valid)
		else $error("result raised after headers ended");

	a_len_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		!stored_q.found |-> stored_q.len == '0)
		else $error("stored length without found flag");

	a_done_then_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_of_message |=> !done_q && !prev_cr_q)
		else $error("message state not cleared at message end");

endmodule

`default_nettype wire

>>> rtl/hcl_out_reg.sv
// Result register that drives the output channel.
`default_nettype none

module hcl_out_reg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  hcl_pkg::result_t res,
	output logic             free,
	hcl_out_if.source        result
);

	logic             valid_q;
	hcl_pkg::result_t res_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	assign result.valid               = valid_q;
	assign result.length_found        = res_q.length_found;
	assign result.content_length      = res_q.content_length;
	assign result.ended_by_blank_line = res_q.ended_by_blank_line;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(valid_q && !result.ready))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> rtl/http_content_length_scanner_top.sv
// Top level of the HTTP content-length scanner.
//
// byte_stream (sink): one header byte per beat, end_of_message on the last
// byte of a message. result (source): one beat per message, at the first
// empty line or, failing that, at the message end; bytes after the empty
// line are swallowed until end_of_message.
// cfg_we/cfg_wdata write max_length (reset 1000000000); write only while idle.
//
// A taken byte is held in the input register and parsed from it; its result,
// if any, is loaded into the result register and driven on the output.
// Throughput: one byte per cycle while the result register can take a result,
// set by the parse step between the input and result registers. Reset clears
// all parse state and both registers' valid flags; no clearing pass.
// While result is stalled, bytes that produce no result still flow; a byte
// that produces one waits in the input register, and byte_stream.ready drops
// until the pending result is taken.
`default_nettype none

module http_content_length_scanner_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	hcl_in_if.sink                           byte_stream,
	hcl_out_if.source                        result,
	input  wire logic                        cfg_we,
	input  wire logic [hcl_pkg::VALUE_W-1:0] cfg_wdata
);

	logic                        s1_valid_q;
	logic [hcl_pkg::BYTE_W-1:0]  byte_s1;
	logic                        eom_s1;
	logic [hcl_pkg::VALUE_W-1:0] max_length_q;
	logic                        res_valid;
	hcl_pkg::result_t            res;
	logic                        out_free;
	logic                        adv;
	logic                        take;

	assign adv               = s1_valid_q && (!res_valid || out_free);
	assign byte_stream.ready = !s1_valid_q || adv;
	assign take              = byte_stream.valid && byte_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			max_length_q <= hcl_pkg::MAX_LENGTH_RESET;
		end else begin
			if (take)
				s1_valid_q <= 1'b1;
			else if (adv)
				s1_valid_q <= 1'b0;
			if (cfg_we)
				max_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= byte_stream.byte_value;
			eom_s1  <= byte_stream.end_of_message;
		end
	end

	hcl_scan_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (adv),
		.byte_value     (byte_s1),
		.end_of_message (eom_s1),
		.max_length     (max_length_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	hcl_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv && res_valid),
		.res    (res),
		.free   (out_free),
		.result (result)
	);

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv |=> s1_valid_q && $stable(byte_s1) && $stable(eom_s1))
		else $error("input register lost a byte");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && res_valid && result.valid && !result.ready |-> !byte_stream.ready)
		else $error("byte taken while result stage blocked");

endmodule

`default_nettype wire
